// ===== hw/rtl/sfcr_pkg.sv =====
// Shared types, constants and font tables for the scaled font character renderer.
`default_nettype none

package sfcr_pkg;

  localparam int PANEL_WIDTH  = 800;
  localparam int PANEL_HEIGHT = 480;
  localparam int ROW_BYTES    = (PANEL_WIDTH + 1) / 2;
  localparam int FB_BYTES     = ROW_BYTES * PANEL_HEIGHT;
  localparam int FB_AW        = $clog2(FB_BYTES);

  localparam int OPC_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int COORD_W  = 12;
  localparam int COLOR_W  = 4;
  localparam int RADDR_W  = 18;
  localparam int DATA_W   = 8;
  localparam int SCALE_W  = 4;
  // pixel coordinate: input position plus up to 6*15+14 of glyph offset
  localparam int POS_W    = 14;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd6;

  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COUNT = 29;
  localparam int SLOT_W      = 5;
  localparam int COL_IDX_W   = $clog2(GLYPH_COLS);
  localparam int ROW_IDX_W   = $clog2(GLYPH_ROWS);

  localparam logic [SLOT_W-1:0] NO_GLYPH    = 5'd31;
  localparam logic [SLOT_W-1:0] SLOT_SPACE  = 5'd0;
  localparam logic [SLOT_W-1:0] SLOT_LPAREN = 5'd27;
  localparam logic [SLOT_W-1:0] SLOT_RPAREN = 5'd28;

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_LPAREN  = 8'd40;
  localparam logic [CHAR_W-1:0] CHAR_RPAREN  = 8'd41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'd122;

  localparam logic [DATA_W-1:0] LO_NIBBLE = 8'h0F;
  localparam logic [DATA_W-1:0] HI_NIBBLE = 8'hF0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // columns of each glyph, bit 0 is the top row
  localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},
    '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41},
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A},
    '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
    '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41},
    '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F},
    '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E},
    '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31},
    '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F},
    '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F},
    '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07},
    '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
    '{8'h00, 8'h1C, 8'h22, 8'h41, 8'h00},
    '{8'h00, 8'h41, 8'h22, 8'h1C, 8'h00}
  };

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_BIT,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_READ,
    ST_RESULT
  } state_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t                       op;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COLOR_W-1:0]        color;
    logic [FB_AW-1:0]          addr;
    logic [SCALE_W-1:0]        scale;
  } cmd_t;

  function automatic logic [SLOT_W-1:0] glyph_slot(input logic [CHAR_W-1:0] code);
    logic [SLOT_W-1:0] slot;
    slot = NO_GLYPH;
    if (code == CHAR_SPACE) begin
      slot = SLOT_SPACE;
    end else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
      slot = SLOT_W'(code - CHAR_UPPER_A + 8'd1);
    end else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
      slot = SLOT_W'(code - CHAR_LOWER_A + 8'd1);
    end else if (code == CHAR_LPAREN) begin
      slot = SLOT_LPAREN;
    end else if (code == CHAR_RPAREN) begin
      slot = SLOT_RPAREN;
    end
    return slot;
  endfunction

  function automatic logic [GLYPH_ROWS-1:0] glyph_col(input logic [SLOT_W-1:0] slot,
                                                      input logic [COL_IDX_W-1:0] col);
    logic [GLYPH_ROWS-1:0] bits;
    bits = '0;
    if (slot < GLYPH_COUNT && col < GLYPH_COLS) begin
      bits = GLYPH_ROM[slot][col][GLYPH_ROWS-1:0];
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sfcr_front.sv =====
// Front end: takes items, holds the scale register and classifies each command.
`default_nettype none

module sfcr_front
  import sfcr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [SCALE_W-1:0]        cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [OPC_W-1:0]          in_opcode,
  input  wire logic [CHAR_W-1:0]         in_char_code,
  input  wire logic signed [COORD_W-1:0] in_x_pos,
  input  wire logic signed [COORD_W-1:0] in_y_pos,
  input  wire logic [COLOR_W-1:0]        in_color,
  input  wire logic [RADDR_W-1:0]        in_read_address,
  input  wire logic                      q_full,
  output logic                           q_push,
  output cmd_t                           q_cmd
);

  logic [SCALE_W-1:0] scale_r;
  logic [SCALE_W-1:0] scale_nxt;
  logic [SLOT_W-1:0]  slot;

  always_comb begin
    scale_nxt = scale_r;
    if (cfg_wr_en) scale_nxt = cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else begin
      scale_r <= scale_nxt;
    end
  end

  assign slot     = glyph_slot(in_char_code);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // draws with no glyph or zero scale and out-of-range reads reduce to a plain zero result
  always_comb begin
    q_cmd       = '0;
    q_cmd.slot  = slot;
    q_cmd.x     = in_x_pos;
    q_cmd.y     = in_y_pos;
    q_cmd.color = in_color;
    q_cmd.addr  = FB_AW'(in_read_address);
    q_cmd.scale = scale_r;
    unique case (op_t'(in_opcode))
      OP_CLEAR: q_cmd.op = OP_CLEAR;
      OP_DRAW:  q_cmd.op = (slot != NO_GLYPH && scale_r != '0) ? OP_DRAW : OP_NONE;
      OP_READ:  q_cmd.op = (in_read_address < FB_BYTES) ? OP_READ : OP_NONE;
      OP_NONE:  q_cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sfcr_cmd_queue.sv =====
// Short command queue between the front end and the render engine.
`default_nettype none

module sfcr_cmd_queue
  import sfcr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      head_cmd
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !pop) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/sfcr_back.sv =====
// Render engine: framebuffer memory, clear sweep, glyph walk with nibble RMW, reads.
`default_nettype none

module sfcr_back
  import sfcr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  cmd_t                    q_cmd,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [DATA_W-1:0]       out_read_data
);

  logic [DATA_W-1:0] fb_r [FB_BYTES];

  state_t state_r, state_nxt;

  cmd_t                     cmd_r, cmd_nxt;
  logic [FB_AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic [COL_IDX_W-1:0]     col_r, col_nxt;
  logic [ROW_IDX_W-1:0]     row_r, row_nxt;
  logic [SCALE_W-1:0]       dx_r, dx_nxt;
  logic [SCALE_W-1:0]       dy_r, dy_nxt;
  logic signed [POS_W-1:0]  base_x_r, base_x_nxt;
  logic signed [POS_W-1:0]  base_y_r, base_y_nxt;
  logic [FB_AW-1:0]         pix_addr_r, pix_addr_nxt;
  logic                     pix_lo_r, pix_lo_nxt;
  logic [DATA_W-1:0]        mem_rdata_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        out_data_r, out_data_nxt;

  logic signed [POS_W-1:0]  scale_ext, dx_ext, dy_ext, px, py, y_ext;
  logic [FB_AW-1:0]         row_off, pix_addr;
  logic [GLYPH_ROWS-1:0]    col_bits;
  logic                     in_panel, bit_lit;
  logic                     last_dx, last_dy, last_row, last_col, pix_done, bit_done;
  logic                     clr_last, adv_pix, adv_bit, out_load;
  logic                     mem_we, mem_re;
  logic [FB_AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_W-1:0]        mem_wdata, merged;

  assign scale_ext = $signed({{(POS_W-SCALE_W){1'b0}}, cmd_r.scale});
  assign dx_ext    = $signed({{(POS_W-SCALE_W){1'b0}}, dx_r});
  assign dy_ext    = $signed({{(POS_W-SCALE_W){1'b0}}, dy_r});
  assign y_ext     = {{(POS_W-COORD_W){cmd_r.y[COORD_W-1]}}, cmd_r.y};
  assign px        = base_x_r + dx_ext;
  assign py        = base_y_r + dy_ext;

  assign in_panel = !px[POS_W-1] && (px[POS_W-2:0] < (POS_W-1)'(PANEL_WIDTH)) &&
                    !py[POS_W-1] && (py[POS_W-2:0] < (POS_W-1)'(PANEL_HEIGHT));
  assign row_off  = FB_AW'(py[POS_W-2:0]) * FB_AW'(ROW_BYTES);
  assign pix_addr = row_off + FB_AW'(px[POS_W-2:1]);

  assign col_bits = glyph_col(cmd_r.slot, col_r);
  assign bit_lit  = col_bits[row_r];
  assign last_dx  = (dx_r == cmd_r.scale - SCALE_W'(1));
  assign last_dy  = (dy_r == cmd_r.scale - SCALE_W'(1));
  assign last_row = (row_r == ROW_IDX_W'(GLYPH_ROWS - 1));
  assign last_col = (col_r == COL_IDX_W'(GLYPH_COLS - 1));
  assign pix_done = last_dx && last_dy;
  assign bit_done = last_row && last_col;
  assign clr_last = (clr_addr_r == FB_AW'(FB_BYTES - 1));

  // left pixel of a byte is the high nibble
  assign merged = pix_lo_r ? ((mem_rdata_r & HI_NIBBLE) | DATA_W'(cmd_r.color))
                           : ((mem_rdata_r & LO_NIBBLE) | {cmd_r.color, 4'h0});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_DRAW:  state_nxt = ST_BIT;
            OP_READ:  state_nxt = ST_READ;
            OP_NONE:  state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_CLEAR:  if (clr_last) state_nxt = ST_RESULT;
      ST_BIT: begin
        if (bit_lit) state_nxt = ST_PIX_RD;
        else if (bit_done) state_nxt = ST_RESULT;
      end
      ST_PIX_RD, ST_PIX_WR: begin
        if (state_r == ST_PIX_RD && in_panel) state_nxt = ST_PIX_WR;
        else if (pix_done && bit_done) state_nxt = ST_RESULT;
        else if (pix_done) state_nxt = ST_BIT;
        else state_nxt = ST_PIX_RD;
      end
      ST_READ:   state_nxt = ST_RESULT;
      ST_RESULT: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    adv_pix   = 1'b0;
    adv_bit   = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = {cmd_r.color, cmd_r.color};
    mem_raddr = pix_addr;
    unique case (state_r)
      ST_IDLE:   q_pop = q_valid;
      ST_CLEAR:  mem_we = 1'b1;
      ST_BIT:    adv_bit = !bit_lit;
      ST_PIX_RD: begin
        mem_re  = in_panel;
        adv_pix = !in_panel;
        adv_bit = !in_panel && pix_done;
      end
      ST_PIX_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pix_addr_r;
        mem_wdata = merged;
        adv_pix   = 1'b1;
        adv_bit   = pix_done;
      end
      ST_READ: begin
        mem_re    = 1'b1;
        mem_raddr = cmd_r.addr;
      end
      ST_RESULT: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // walk counters and datapath registers
  always_comb begin
    cmd_nxt       = cmd_r;
    clr_addr_nxt  = clr_addr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    base_x_nxt    = base_x_r;
    base_y_nxt    = base_y_r;
    pix_addr_nxt  = pix_addr_r;
    pix_lo_nxt    = pix_lo_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      cmd_nxt      = q_cmd;
      clr_addr_nxt = '0;
      col_nxt      = '0;
      row_nxt      = '0;
      dx_nxt       = '0;
      dy_nxt       = '0;
      base_x_nxt   = {{(POS_W-COORD_W){q_cmd.x[COORD_W-1]}}, q_cmd.x};
      base_y_nxt   = {{(POS_W-COORD_W){q_cmd.y[COORD_W-1]}}, q_cmd.y};
    end
    if (state_r == ST_CLEAR) clr_addr_nxt = clr_addr_r + 1'b1;
    if (state_r == ST_PIX_RD && in_panel) begin
      pix_addr_nxt = pix_addr;
      pix_lo_nxt   = px[0];
    end
    // dy runs fastest, then dx, then the font bit
    if (adv_pix) begin
      if (last_dy) begin
        dy_nxt = '0;
        dx_nxt = last_dx ? '0 : dx_r + 1'b1;
      end else begin
        dy_nxt = dy_r + 1'b1;
      end
    end
    if (adv_bit) begin
      if (last_row) begin
        row_nxt    = '0;
        base_y_nxt = y_ext;
        col_nxt    = last_col ? '0 : col_r + 1'b1;
        base_x_nxt = base_x_r + scale_ext;
      end else begin
        row_nxt    = row_r + 1'b1;
        base_y_nxt = base_y_r + scale_ext;
      end
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = (cmd_r.op == OP_READ) ? mem_rdata_r : '0;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    clr_addr_r <= clr_addr_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    base_x_r   <= base_x_nxt;
    base_y_r   <= base_y_nxt;
    pix_addr_r <= pix_addr_nxt;
    pix_lo_r   <= pix_lo_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) fb_r[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) mem_rdata_r <= fb_r[mem_raddr];
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  a_wr_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PIX_WR |-> $past(state_r) == ST_PIX_RD)
    else $error("pixel write without preceding read");
  a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re)) else $error("read and write in same cycle");
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PIX_RD || state_r == ST_PIX_WR) |->
      (dx_r < cmd_r.scale && dy_r < cmd_r.scale && col_r < COL_IDX_W'(GLYPH_COLS)))
    else $error("glyph walk counter out of range");
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && out_valid_r && out_stall) |=> state_r == ST_RESULT)
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/scaled_font_char_renderer.sv =====
// Top level of the scaled 5x7 font character renderer.
//
//   port group | dir | handshake           | payload
//   cfg_       | in  | cfg_wr_en           | cfg_wr_data (glyph scale)
//   in_        | in  | in_valid / in_stall | opcode, char_code, x/y_pos, color, read_address
//   out_       | out | out_valid/out_stall | read_data
//
// Clear: one byte per cycle over all FB_BYTES of the framebuffer.
// Draw: 35 font-bit steps plus, per lit bit, scale^2 pixels, each a read then a write
//   on panel (single-port read-modify-write) and no write when clipped.
// Read: one framebuffer read; other ops, no-glyph or zero-scale draws go to the result.
//   A two-entry queue lets items in while the engine works; the output register
//   holds a result under out_stall.
// Reset clears control only; framebuffer contents are undefined until a clear.
`default_nettype none

module scaled_font_char_renderer
  import sfcr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [SCALE_W-1:0]        cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [OPC_W-1:0]          in_opcode,
  input  wire logic [CHAR_W-1:0]         in_char_code,
  input  wire logic signed [COORD_W-1:0] in_x_pos,
  input  wire logic signed [COORD_W-1:0] in_y_pos,
  input  wire logic [COLOR_W-1:0]        in_color,
  input  wire logic [RADDR_W-1:0]        in_read_address,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [DATA_W-1:0]              out_read_data
);

  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  sfcr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_char_code    (in_char_code),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_color        (in_color),
    .in_read_address (in_read_address),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  sfcr_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .head_cmd (head_cmd)
  );

  sfcr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_cmd         (head_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data)
  );

endmodule

`default_nettype wire
